FILE: src/edf_pkg.sv
// shared types and constants of the edf task picker with frequency choice
// no dependencies; used by the top level and its checker
package edf_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_SORT_INIT,
        S_SORT_SCAN,
        S_SORT_SWAP,
        S_DEC_SUM,
        S_DEC_MARGIN,
        S_DEC_CMP
    } t_state;

    // item commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SCHED = 1'b1;

    // register map (index taken from paddr[2])
    localparam logic REG_MARGIN = 1'b0;

    localparam int        MARGIN_W     = 20;
    localparam logic [19:0] MARGIN_RESET = 20'd10000;
    localparam int        FIELD_TIME_W = 40;
    localparam int        MASK_W       = 8;

endpackage

FILE: src/edf_task_select_with_dvfs_top.sv
// edf task picker with a two-level frequency choice, top level
// depends on edf_pkg; a single shared adder and comparator under a small sequencer
//
// usage
//   command channel: an item is taken at a clock edge with start high and busy low.
//   a load item (i_cmd = 0) writes the deadline and run times of task i_task_index
//   in that same edge, produces no result and leaves busy low.
//   a schedule item (i_cmd = 1) walks all tasks, sorts the ready queue by
//   absolute deadline and picks the frequency; the result shows for one cycle
//   with o_done high, and busy drops in that same cycle.
//   steps of a schedule item: the walk over all TASK_COUNT tasks (one task per
//   cycle through the shared adder), then for a queue of n >= 2 entries the
//   selection sort (one queue read and one deadline compare per scan cycle), then
//   the decision states S_DEC_SUM, S_DEC_MARGIN and S_DEC_CMP, then o_done.
//   the next item may start in the cycle o_done is high.
//   the receiver cannot stall: o_done is a one-cycle strobe.
//   config: apb write with paddr[2] = 0 sets margin_us; pready is always high;
//   write only while idle.
//   reset (synchronous, active low) clears all tables, the queue, the totals,
//   selects low frequency and sets margin_us to 10000.
module edf_task_select_with_dvfs_top
    import edf_pkg::*;
#(
    parameter int TASK_COUNT = 8,
    parameter int TIME_BITS  = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [2:0]  i_task_index,
    input  logic [39:0] i_rel_deadline,
    input  logic [39:0] i_exec_fast,
    input  logic [39:0] i_exec_slow,
    input  logic [7:0]  i_alive_mask,
    input  logic [39:0] i_now_us,
    input  logic [39:0] i_idle_us,
    // result strobe
    output logic        o_done,
    output logic [2:0]  o_chosen_task,
    output logic        o_high_freq,
    output logic [39:0] o_active_fast_total,
    output logic [39:0] o_active_slow_total,
    output logic [39:0] o_idle_total,
    // apb config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int CNT_W = $clog2(TASK_COUNT + 1);
    // wide enough for slow + now + margin without loss
    localparam int SUM_W = TIME_BITS + 2;

    // task tables
    logic [TIME_BITS-1:0]  r_rel_tab  [TASK_COUNT];
    logic [TIME_BITS-1:0]  r_fast_tab [TASK_COUNT];
    logic [TIME_BITS-1:0]  r_slow_tab [TASK_COUNT];
    logic [TIME_BITS-1:0]  r_abs_dl   [TASK_COUNT];
    logic [TASK_COUNT-1:0] r_was_ready;
    logic [IDX_W-1:0]      r_queue    [TASK_COUNT];

    // sequencer and datapath registers
    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_i, n_i;
    logic [IDX_W-1:0]     r_j, n_j;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [IDX_W-1:0]     r_best_idx, n_best_idx;
    logic [IDX_W-1:0]     r_best_task, n_best_task;
    logic [TIME_BITS-1:0] r_best_dl, n_best_dl;
    logic [IDX_W-1:0]     r_qi, n_qi;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic                 r_fast_ok, n_fast_ok;
    logic                 r_freq, n_freq;
    logic                 r_done, n_done;
    logic [2:0]           r_chosen, n_chosen;
    logic [MASK_W-1:0]    r_mask;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_idle;
    logic [TIME_BITS-1:0] r_fast_acc;
    logic [TIME_BITS-1:0] r_slow_acc;
    logic [TIME_BITS-1:0] r_idle_acc;
    logic [MARGIN_W-1:0]  r_margin;

    // handshake decode
    logic w_accept;
    logic w_ld_ok;
    logic [IDX_W-1:0] w_ld_idx;
    logic w_cfg_wr;

    // shared read ports
    logic [IDX_W-1:0]     w_head;
    logic                 w_dec;
    logic [IDX_W-1:0]     w_tab_idx;
    logic [IDX_W-1:0]     w_q_rd_addr;
    logic [IDX_W-1:0]     w_q_rd;
    logic [IDX_W-1:0]     w_dl_addr;
    logic [TIME_BITS-1:0] w_dl_rd;
    logic [TIME_BITS-1:0] w_rel_rd;
    logic [TIME_BITS-1:0] w_fast_rd;
    logic [TIME_BITS-1:0] w_slow_rd;

    // walk step decode
    logic [4:0] w_i_ext;
    logic       w_alive;
    logic       w_new;
    logic       w_gone;

    // the shared adder and comparator
    logic [SUM_W-1:0] w_add_a, w_add_b, w_sum;
    logic [SUM_W-1:0] w_cmp_a, w_cmp_b;
    logic             w_gt;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_ld_ok  = (5'(i_task_index) < 5'(TASK_COUNT));
    assign w_ld_idx = IDX_W'(i_task_index);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MARGIN) ? 32'(r_margin) : 32'd0;

    // table reads go to the walk index, or to the queue head while deciding
    assign w_head    = r_queue[0];
    assign w_dec     = (r_state == S_DEC_SUM) || (r_state == S_DEC_MARGIN)
                    || (r_state == S_DEC_CMP);
    assign w_tab_idx = w_dec ? w_head : r_i;
    assign w_rel_rd  = r_rel_tab[w_tab_idx];
    assign w_fast_rd = r_fast_tab[w_tab_idx];
    assign w_slow_rd = r_slow_tab[w_tab_idx];

    // one queue read a cycle: tail during the walk, start or scan slot during the sort
    always_comb begin
        case (r_state)
            S_WALK:      w_q_rd_addr = IDX_W'(r_cnt - CNT_W'(1));
            S_SORT_INIT: w_q_rd_addr = r_i;
            S_SORT_SCAN: w_q_rd_addr = r_j;
            default:     w_q_rd_addr = '0;
        endcase
    end
    assign w_q_rd    = r_queue[w_q_rd_addr];
    assign w_dl_addr = w_dec ? w_head : w_q_rd;
    assign w_dl_rd   = r_abs_dl[w_dl_addr];

    // alive bits exist for the first eight tasks only
    assign w_i_ext = 5'(r_i);
    assign w_alive = (w_i_ext < 5'd8) && r_mask[w_i_ext[2:0]];
    assign w_new   = w_alive && !r_was_ready[r_i];
    assign w_gone  = !w_alive && r_was_ready[r_i];

    // operand selection for the shared adder and comparator
    always_comb begin
        w_add_a = '0;
        w_add_b = '0;
        w_cmp_a = '0;
        w_cmp_b = '0;
        case (r_state)
            S_WALK: begin
                if (w_new) begin
                    // absolute deadline of a newly ready task
                    w_add_a = SUM_W'(r_now);
                    w_add_b = SUM_W'(w_rel_rd);
                end else if (r_freq) begin
                    w_add_a = SUM_W'(r_fast_acc);
                    w_add_b = SUM_W'(w_fast_rd);
                end else begin
                    w_add_a = SUM_W'(r_slow_acc);
                    w_add_b = SUM_W'(w_slow_rd);
                end
            end
            S_SORT_SCAN: begin
                w_cmp_a = SUM_W'(r_best_dl);
                w_cmp_b = SUM_W'(w_dl_rd);
            end
            S_DEC_SUM: begin
                w_add_a = SUM_W'(w_slow_rd);
                w_add_b = SUM_W'(r_now);
            end
            S_DEC_MARGIN: begin
                w_add_a = r_sum;
                w_add_b = SUM_W'(r_margin);
                // slow time worth it: fast > slow / 2
                w_cmp_a = SUM_W'(w_fast_rd);
                w_cmp_b = SUM_W'(w_slow_rd >> 1);
            end
            S_DEC_CMP: begin
                w_add_a = SUM_W'(r_idle_acc);
                w_add_b = SUM_W'(r_idle);
                // deadline still met at slow speed plus margin
                w_cmp_a = SUM_W'(w_dl_rd);
                w_cmp_b = r_sum;
            end
            default: begin
                w_add_a = '0;
            end
        endcase
    end

    assign w_sum = w_add_a + w_add_b;
    assign w_gt  = (w_cmp_a > w_cmp_b);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_cnt       = r_cnt;
        n_best_idx  = r_best_idx;
        n_best_task = r_best_task;
        n_best_dl   = r_best_dl;
        n_qi        = r_qi;
        n_sum       = r_sum;
        n_fast_ok   = r_fast_ok;
        n_freq      = r_freq;
        n_done      = 1'b0;
        n_chosen    = r_chosen;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_cmd == CMD_SCHED) begin
                    n_state = S_WALK;
                    n_i     = '0;
                end
            end
            S_WALK: begin
                if (w_new && r_cnt < CNT_W'(TASK_COUNT)) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (w_gone && r_cnt != '0) begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
                if (r_i == IDX_W'(TASK_COUNT - 1)) begin
                    n_i = '0;
                    if (n_cnt >= CNT_W'(2)) begin
                        n_state = S_SORT_INIT;
                    end else begin
                        n_state = S_DEC_SUM;
                    end
                end else begin
                    n_i = r_i + IDX_W'(1);
                end
            end
            S_SORT_INIT: begin
                n_best_idx  = r_i;
                n_best_task = w_q_rd;
                n_best_dl   = w_dl_rd;
                n_qi        = w_q_rd;
                n_j         = r_i + IDX_W'(1);
                n_state     = S_SORT_SCAN;
            end
            S_SORT_SCAN: begin
                // strict compare keeps the first minimum
                if (w_gt) begin
                    n_best_idx  = r_j;
                    n_best_task = w_q_rd;
                    n_best_dl   = w_dl_rd;
                end
                if (CNT_W'(r_j) + CNT_W'(1) == r_cnt) begin
                    n_state = S_SORT_SWAP;
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            S_SORT_SWAP: begin
                if (CNT_W'(r_i) + CNT_W'(2) < r_cnt) begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_SORT_INIT;
                end else begin
                    n_state = S_DEC_SUM;
                end
            end
            S_DEC_SUM: begin
                n_sum   = w_sum;
                n_state = S_DEC_MARGIN;
            end
            S_DEC_MARGIN: begin
                n_sum     = w_sum;
                n_fast_ok = w_gt;
                n_state   = S_DEC_CMP;
            end
            S_DEC_CMP: begin
                n_freq   = !(r_fast_ok && w_gt);
                n_chosen = 3'(w_head);
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_cnt       <= '0;
            r_freq      <= 1'b0;
            r_done      <= 1'b0;
            r_chosen    <= '0;
            r_fast_acc  <= '0;
            r_slow_acc  <= '0;
            r_idle_acc  <= '0;
            r_margin    <= MARGIN_RESET;
            r_was_ready <= '0;
            for (int k = 0; k < TASK_COUNT; k++) begin
                r_rel_tab[k]  <= '0;
                r_fast_tab[k] <= '0;
                r_slow_tab[k] <= '0;
                r_abs_dl[k]   <= '0;
                r_queue[k]    <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_cnt       <= n_cnt;
            r_freq      <= n_freq;
            r_done      <= n_done;
            r_chosen    <= n_chosen;

            if (w_cfg_wr && paddr[2] == REG_MARGIN) begin
                r_margin <= pwdata[MARGIN_W-1:0];
            end

            if (w_accept && i_cmd == CMD_LOAD && w_ld_ok) begin
                r_rel_tab[w_ld_idx]  <= TIME_BITS'(i_rel_deadline);
                r_fast_tab[w_ld_idx] <= TIME_BITS'(i_exec_fast);
                r_slow_tab[w_ld_idx] <= TIME_BITS'(i_exec_slow);
            end

            if (r_state == S_WALK) begin
                if (w_new) begin
                    r_was_ready[r_i] <= 1'b1;
                    r_abs_dl[r_i]    <= TIME_BITS'(w_sum);
                    if (r_cnt < CNT_W'(TASK_COUNT)) begin
                        r_queue[IDX_W'(r_cnt)] <= r_i;
                    end
                end else if (w_gone) begin
                    r_was_ready[r_i] <= 1'b0;
                    // tail moves to the head, vacated slot reads as task 0
                    if (r_cnt != '0) begin
                        if (r_cnt != CNT_W'(1)) begin
                            r_queue[0] <= w_q_rd;
                        end
                        r_queue[w_q_rd_addr] <= '0;
                    end
                    if (r_freq) begin
                        r_fast_acc <= TIME_BITS'(w_sum);
                    end else begin
                        r_slow_acc <= TIME_BITS'(w_sum);
                    end
                end
            end

            if (r_state == S_SORT_SWAP) begin
                if (r_best_idx != r_i) begin
                    r_queue[r_best_idx] <= r_qi;
                end
                r_queue[r_i] <= r_best_task;
            end

            if (r_state == S_DEC_CMP) begin
                r_idle_acc <= TIME_BITS'(w_sum);
            end
        end
    end

    // payload registers without reset
    always_ff @(posedge i_clk) begin
        r_best_idx  <= n_best_idx;
        r_best_task <= n_best_task;
        r_best_dl   <= n_best_dl;
        r_qi        <= n_qi;
        r_sum       <= n_sum;
        r_fast_ok   <= n_fast_ok;
        if (w_accept && i_cmd == CMD_SCHED) begin
            r_mask <= i_alive_mask;
            r_now  <= TIME_BITS'(i_now_us);
            r_idle <= TIME_BITS'(i_idle_us);
        end
    end

    // result ports
    assign o_done              = r_done;
    assign o_chosen_task       = r_chosen;
    assign o_high_freq         = r_freq;
    assign o_active_fast_total = FIELD_TIME_W'(r_fast_acc);
    assign o_active_slow_total = FIELD_TIME_W'(r_slow_acc);
    assign o_idle_total        = FIELD_TIME_W'(r_idle_acc);

endmodule

FILE: src/edf_checker.sv
// port-level checks for the edf task picker, bound to the top level
// depends on edf_pkg and edf_task_select_with_dvfs_top
module edf_checker
    import edf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_cmd,
    input logic o_done
);

    // a result only shows once the block has let go of busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // a load item leaves busy low and produces no result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_LOAD) |=> (!busy && !o_done))
        else $error("load item caused busy or a result");

    // a schedule item holds the block busy
    a_sched_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_SCHED) |=> busy)
        else $error("schedule item did not raise busy");

    // the result strobe is never high twice in a row
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

endmodule

bind edf_task_select_with_dvfs_top edf_checker u_edf_checker (.*);
